FILE: hw/rtl/scheduled_transmit_key_watchdog_macros.svh
// Assertion macros for the transmit key watchdog.
`ifndef SCHEDULED_TRANSMIT_KEY_WATCHDOG_MACROS_SVH
`define SCHEDULED_TRANSMIT_KEY_WATCHDOG_MACROS_SVH

`ifndef ASSERT_OFF

`define STKW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define STKW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define STKW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STKW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/stkw_pkg.sv
`default_nettype none

package stkw_pkg;

    localparam int unsigned CLOCK_W = 63;
    localparam int unsigned HOLD_W  = 32;

    localparam logic [HOLD_W-1:0] MAX_HOLD_RESET = 32'd20000;

    // action codes
    localparam logic [3:0] ACT_TICK     = 4'd0;
    localparam logic [3:0] ACT_PING     = 4'd1;
    localparam logic [3:0] ACT_STATUS   = 4'd2;
    localparam logic [3:0] ACT_SHUTDOWN = 4'd3;
    localparam logic [3:0] ACT_RESUME   = 4'd4;
    localparam logic [3:0] ACT_SET_TIME = 4'd5;
    localparam logic [3:0] ACT_KEY_ON   = 4'd6;
    localparam logic [3:0] ACT_KEY_OFF  = 4'd7;
    localparam logic [3:0] ACT_ARM      = 4'd8;

    // reply codes
    localparam logic [2:0] REPLY_NONE    = 3'd0;
    localparam logic [2:0] REPLY_OK      = 3'd1;
    localparam logic [2:0] REPLY_PONG    = 3'd2;
    localparam logic [2:0] REPLY_REFUSED = 3'd3;
    localparam logic [2:0] REPLY_FIRED   = 3'd4;
    localparam logic [2:0] REPLY_TRIP    = 3'd5;
    localparam logic [2:0] REPLY_ARMED   = 3'd6;
    localparam logic [2:0] REPLY_STATUS  = 3'd7;

    typedef struct packed {
        logic [3:0]         action;
        logic [CLOCK_W-1:0] time_value;
        logic               armed_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         reply;
        logic               key_level;
        logic               lock_flag;
        logic [CLOCK_W-1:0] clock_now;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scheduled_transmit_key_watchdog.sv
// Transmit key controller with one armed timed change and a hold watchdog.
// Accepts one item (tick or decoded command) per clock cycle when the result
// side keeps up; each item gives exactly one result, presented on m_valid once
// the item has passed the input register, where it waits while the state
// update runs, and the result register, which captures the outcome when the
// result side can take it. The hold limit max_hold_reg, counted in ticks, is
// written through cfg_wr_en and cfg_wr_data and resets to 20000; the user must
// write it only while no item is in flight, which the block does not enforce.
`default_nettype none
`include "scheduled_transmit_key_watchdog_macros.svh"

module scheduled_transmit_key_watchdog (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [stkw_pkg::HOLD_W-1:0]   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire stkw_pkg::in_item_t            s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output stkw_pkg::out_item_t                m_item
);

    logic                in_valid;
    stkw_pkg::in_item_t  in_item;
    logic                out_can_load;
    logic                advance;
    stkw_pkg::out_item_t result;

    assign advance = in_valid && out_can_load;

    stkw_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take    (advance),
        .valid   (in_valid),
        .item    (in_item)
    );

    stkw_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (in_item),
        .result      (result)
    );

    stkw_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .data     (result),
        .can_load (out_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    `STKW_ASSERT_IMPL(a_trip_locks, aclk, aresetn, m_valid && (m_item.reply == stkw_pkg::REPLY_TRIP), !m_item.key_level && m_item.lock_flag)
    `STKW_ASSERT_IMPL(a_refused_locked, aclk, aresetn, m_valid && (m_item.reply == stkw_pkg::REPLY_REFUSED), m_item.lock_flag)
    `STKW_ASSERT_NEXT(a_in_held, aclk, aresetn, in_valid && !advance, in_valid)
    `STKW_ASSERT_NEXT(a_result_lands, aclk, aresetn, advance, m_valid)

endmodule

`default_nettype wire

FILE: hw/rtl/stkw_in_reg.sv
`default_nettype none

module stkw_in_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire stkw_pkg::in_item_t s_item,
    input  wire logic             take,
    output logic                  valid,
    output stkw_pkg::in_item_t    item
);

    logic               valid_reg;
    logic               valid_next;
    stkw_pkg::in_item_t item_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/stkw_ctrl.sv
`default_nettype none

module stkw_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [stkw_pkg::HOLD_W-1:0]   cfg_wr_data,
    input  wire logic                          step,
    input  wire stkw_pkg::in_item_t            item,
    output stkw_pkg::out_item_t                result
);

    logic                          key_reg, key_next;
    logic                          lock_reg, lock_next;
    logic                          pending_reg, pending_next;
    logic                          level_reg, level_next;
    logic [stkw_pkg::CLOCK_W-1:0]  sched_time_reg, sched_time_next;
    logic [stkw_pkg::CLOCK_W-1:0]  clock_reg, clock_next;
    logic [stkw_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [stkw_pkg::HOLD_W-1:0]   max_hold_reg;
    logic [2:0]                    reply;
    logic                          fired;

    always_comb begin
        key_next        = key_reg;
        lock_next       = lock_reg;
        pending_next    = pending_reg;
        level_next      = level_reg;
        sched_time_next = sched_time_reg;
        clock_next      = clock_reg;
        hold_next       = hold_reg;
        reply           = stkw_pkg::REPLY_NONE;
        fired           = 1'b0;

        case (item.action)
            stkw_pkg::ACT_TICK: begin
                clock_next = clock_reg + 63'd1;
                // a due armed change goes first
                if (pending_reg && (clock_next >= sched_time_reg)) begin
                    key_next     = level_reg;
                    hold_next    = '0;
                    pending_next = 1'b0;
                    fired        = 1'b1;
                    reply        = stkw_pkg::REPLY_FIRED;
                end
                if (key_next) begin
                    if (!fired && (hold_reg != '1)) begin
                        hold_next = hold_reg + 32'd1;
                    end
                    if (hold_next >= max_hold_reg) begin
                        key_next     = 1'b0;
                        hold_next    = '0;
                        pending_next = 1'b0;
                        lock_next    = 1'b1;
                        reply        = stkw_pkg::REPLY_TRIP;
                    end
                end
            end
            stkw_pkg::ACT_PING: begin
                reply = stkw_pkg::REPLY_PONG;
            end
            stkw_pkg::ACT_STATUS: begin
                reply = stkw_pkg::REPLY_STATUS;
            end
            stkw_pkg::ACT_SHUTDOWN: begin
                pending_next = 1'b0;
                lock_next    = 1'b1;
                key_next     = 1'b0;
                hold_next    = '0;
                reply        = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_RESUME: begin
                lock_next = 1'b0;
                key_next  = 1'b0;
                hold_next = '0;
                reply     = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_SET_TIME: begin
                clock_next = item.time_value;
                reply      = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_KEY_ON: begin
                if (lock_reg) begin
                    reply = stkw_pkg::REPLY_REFUSED;
                end else begin
                    key_next  = 1'b1;
                    hold_next = '0;
                    reply     = stkw_pkg::REPLY_OK;
                end
            end
            stkw_pkg::ACT_KEY_OFF: begin
                key_next  = 1'b0;
                hold_next = '0;
                reply     = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_ARM: begin
                sched_time_next = item.time_value;
                level_next      = item.armed_level;
                pending_next    = 1'b1;
                reply           = stkw_pkg::REPLY_ARMED;
            end
            default: begin
                reply = stkw_pkg::REPLY_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg        <= 1'b0;
            lock_reg       <= 1'b0;
            pending_reg    <= 1'b0;
            level_reg      <= 1'b0;
            sched_time_reg <= '0;
            clock_reg      <= '0;
            hold_reg       <= '0;
        end else if (step) begin
            key_reg        <= key_next;
            lock_reg       <= lock_next;
            pending_reg    <= pending_next;
            level_reg      <= level_next;
            sched_time_reg <= sched_time_next;
            clock_reg      <= clock_next;
            hold_reg       <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hold_reg <= stkw_pkg::MAX_HOLD_RESET;
        end else if (cfg_wr_en) begin
            max_hold_reg <= cfg_wr_data;
        end
    end

    assign result.reply     = reply;
    assign result.key_level = key_next;
    assign result.lock_flag = lock_next;
    assign result.clock_now = clock_next;

endmodule

`default_nettype wire

FILE: hw/rtl/stkw_out_reg.sv
`default_nettype none

module stkw_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire stkw_pkg::out_item_t data,
    output logic                  can_load,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output stkw_pkg::out_item_t   m_item
);

    logic                valid_reg;
    logic                valid_next;
    stkw_pkg::out_item_t item_reg;

    // free when empty or the waiting item leaves this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= data;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

FILE: verif/scheduled_transmit_key_watchdog_tb.sv
`timescale 1ns / 100ps

module scheduled_transmit_key_watchdog_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;
    localparam logic [stkw_pkg::CLOCK_W-1:0] CLOCK_TOP = {stkw_pkg::CLOCK_W{1'b1}};

    typedef struct {
        logic                        wr_limit;
        logic [stkw_pkg::HOLD_W-1:0] limit;
        stkw_pkg::in_item_t          item;
        logic                        typed;
        stkw_pkg::out_item_t         want;
    } step_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [stkw_pkg::HOLD_W-1:0] cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    stkw_pkg::in_item_t          s_item;
    logic                        m_valid;
    logic                        m_ready;
    stkw_pkg::out_item_t         m_item;

    // predicted controller state
    logic                         p_key;
    logic                         p_lock;
    logic                         p_armed;
    logic                         p_arm_level;
    logic [stkw_pkg::CLOCK_W-1:0] p_arm_time;
    logic [stkw_pkg::CLOCK_W-1:0] p_clock;
    logic [stkw_pkg::HOLD_W-1:0]  p_hold;
    logic [stkw_pkg::HOLD_W-1:0]  p_limit;

    stkw_pkg::out_item_t pending_replies[$];
    step_row_t           dir_rows[$];
    int                  mismatch_cnt;
    int                  stall_cnt;
    logic                hold_off_req;
    logic                hold_done;
    logic                no_idle;

    scheduled_transmit_key_watchdog dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic stkw_pkg::out_item_t key_ctrl_apply(stkw_pkg::in_item_t it);
        stkw_pkg::out_item_t res;
        logic                fired;
        res.reply = stkw_pkg::REPLY_NONE;
        fired = 1'b0;
        case (it.action)
            stkw_pkg::ACT_TICK: begin
                p_clock = p_clock + 63'd1;
                if (p_armed && p_clock >= p_arm_time) begin
                    p_key = p_arm_level;
                    p_hold = '0;
                    p_armed = 1'b0;
                    fired = 1'b1;
                    res.reply = stkw_pkg::REPLY_FIRED;
                end
                if (p_key) begin
                    if (!fired && p_hold != '1) p_hold = p_hold + 32'd1;
                    // trip: key off, drop the armed change, lock
                    if (p_hold >= p_limit) begin
                        p_key = 1'b0;
                        p_hold = '0;
                        p_armed = 1'b0;
                        p_lock = 1'b1;
                        res.reply = stkw_pkg::REPLY_TRIP;
                    end
                end
            end
            stkw_pkg::ACT_PING: res.reply = stkw_pkg::REPLY_PONG;
            stkw_pkg::ACT_STATUS: res.reply = stkw_pkg::REPLY_STATUS;
            stkw_pkg::ACT_SHUTDOWN: begin
                p_armed = 1'b0;
                p_lock = 1'b1;
                p_key = 1'b0;
                p_hold = '0;
                res.reply = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_RESUME: begin
                p_lock = 1'b0;
                p_key = 1'b0;
                p_hold = '0;
                res.reply = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_SET_TIME: begin
                p_clock = it.time_value;
                res.reply = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_KEY_ON: begin
                if (p_lock) begin
                    res.reply = stkw_pkg::REPLY_REFUSED;
                end else begin
                    p_key = 1'b1;
                    p_hold = '0;
                    res.reply = stkw_pkg::REPLY_OK;
                end
            end
            stkw_pkg::ACT_KEY_OFF: begin
                p_key = 1'b0;
                p_hold = '0;
                res.reply = stkw_pkg::REPLY_OK;
            end
            stkw_pkg::ACT_ARM: begin
                p_arm_time = it.time_value;
                p_arm_level = it.armed_level;
                p_armed = 1'b1;
                res.reply = stkw_pkg::REPLY_ARMED;
            end
            default: ;
        endcase
        res.key_level = p_key;
        res.lock_flag = p_lock;
        res.clock_now = p_clock;
        return res;
    endfunction

    function automatic stkw_pkg::in_item_t random_command();
        stkw_pkg::in_item_t it;
        logic [63:0]        r64;
        int unsigned        sel;
        r64 = {$urandom, $urandom};
        it.time_value = r64[stkw_pkg::CLOCK_W-1:0];
        it.armed_level = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            it.action = stkw_pkg::ACT_TICK;
        end else if (sel < 53) begin
            it.action = stkw_pkg::ACT_KEY_ON;
        end else if (sel < 58) begin
            it.action = stkw_pkg::ACT_KEY_OFF;
        end else if (sel < 68) begin
            it.action = stkw_pkg::ACT_ARM;
            // mostly a target a few ticks ahead, so that it fires
            if ($urandom_range(0, 9) < 8)
                it.time_value = p_clock + 63'($urandom_range(0, 12));
        end else if (sel < 72) begin
            it.action = stkw_pkg::ACT_SET_TIME;
            if ($urandom_range(0, 1) == 1)
                it.time_value = CLOCK_TOP - 63'($urandom_range(0, 8));
        end else if (sel < 77) begin
            it.action = stkw_pkg::ACT_SHUTDOWN;
        end else if (sel < 84) begin
            it.action = stkw_pkg::ACT_RESUME;
        end else if (sel < 89) begin
            it.action = stkw_pkg::ACT_PING;
        end else if (sel < 94) begin
            it.action = stkw_pkg::ACT_STATUS;
        end else begin
            it.action = 4'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
        end
        return it;
    endfunction

    function automatic step_row_t mk(logic wr, logic [stkw_pkg::HOLD_W-1:0] lim,
                                     logic [3:0] act, logic [stkw_pkg::CLOCK_W-1:0] tv,
                                     logic lvl, logic typed,
                                     logic [2:0] rp, logic k, logic l,
                                     logic [stkw_pkg::CLOCK_W-1:0] c);
        step_row_t row;
        row.wr_limit = wr;
        row.limit = lim;
        row.item.action = act;
        row.item.time_value = tv;
        row.item.armed_level = lvl;
        row.typed = typed;
        row.want.reply = rp;
        row.want.key_level = k;
        row.want.lock_flag = l;
        row.want.clock_now = c;
        return row;
    endfunction

    task automatic send_item(stkw_pkg::in_item_t it, logic typed, stkw_pkg::out_item_t want);
        stkw_pkg::out_item_t predicted;
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = key_ctrl_apply(it);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(logic [stkw_pkg::HOLD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        p_limit = value;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge aclk) begin
        stkw_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected item %h", $time, m_item);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                want = pending_replies.pop_front();
                if (m_item.reply !== want.reply) begin
                    $display("%0t: reply expected %0d actual %0d",
                             $time, want.reply, m_item.reply);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (m_item.key_level !== want.key_level) begin
                    $display("%0t: key_level expected %0b actual %0b",
                             $time, want.key_level, m_item.key_level);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (m_item.lock_flag !== want.lock_flag) begin
                    $display("%0t: lock_flag expected %0b actual %0b",
                             $time, want.lock_flag, m_item.lock_flag);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (m_item.clock_now !== want.clock_now) begin
                    $display("%0t: clock_now expected %0d actual %0d",
                             $time, want.clock_now, m_item.clock_now);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("scheduled_transmit_key_watchdog_tb: FAIL");
            $finish;
        end
    end

    initial begin
        stkw_pkg::out_item_t none_want;
        stkw_pkg::in_item_t  it;
        logic [31:0]         lim;
        none_want = '0;
        hold_off_req = 1'b0;
        no_idle = 1'b0;
        p_key = 1'b0;
        p_lock = 1'b0;
        p_armed = 1'b0;
        p_arm_level = 1'b0;
        p_arm_time = '0;
        p_clock = '0;
        p_hold = '0;
        p_limit = stkw_pkg::MAX_HOLD_RESET;

        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_item <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows: limit write, action, time, level, typed?, reply, key, lock, clock
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_PING, 0, 0, 1,
                              stkw_pkg::REPLY_PONG, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_STATUS, CLOCK_TOP, 1, 1,
                              stkw_pkg::REPLY_STATUS, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, ACT_UNKNOWN_HI, CLOCK_TOP, 1, 1,
                              stkw_pkg::REPLY_NONE, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, ACT_UNKNOWN_LO, 0, 0, 1,
                              stkw_pkg::REPLY_NONE, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 1,
                              stkw_pkg::REPLY_NONE, 0, 0, 1));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_SET_TIME, CLOCK_TOP, 0, 1,
                              stkw_pkg::REPLY_OK, 0, 0, CLOCK_TOP));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 1,
                              stkw_pkg::REPLY_NONE, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_KEY_ON, 0, 0, 1,
                              stkw_pkg::REPLY_OK, 1, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_SHUTDOWN, 0, 0, 1,
                              stkw_pkg::REPLY_OK, 0, 1, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_KEY_ON, 0, 0, 1,
                              stkw_pkg::REPLY_REFUSED, 0, 1, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_ARM, 2, 1, 1,
                              stkw_pkg::REPLY_ARMED, 0, 1, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        // armed key-on fires despite the lock
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 1,
                              stkw_pkg::REPLY_FIRED, 1, 1, 2));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_RESUME, 0, 0, 1,
                              stkw_pkg::REPLY_OK, 0, 0, 2));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_KEY_OFF, 0, 0, 1,
                              stkw_pkg::REPLY_OK, 0, 0, 2));
        dir_rows.push_back(mk(1, 3, stkw_pkg::ACT_KEY_ON, 0, 0, 1,
                              stkw_pkg::REPLY_OK, 1, 0, 2));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 1,
                              stkw_pkg::REPLY_TRIP, 0, 1, 5));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_RESUME, 0, 0, 0, 0, 0, 0, 0));
        // zero limit: fire and trip on the same tick
        dir_rows.push_back(mk(1, 0, stkw_pkg::ACT_ARM, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 1,
                              stkw_pkg::REPLY_TRIP, 0, 1, 6));
        dir_rows.push_back(mk(1, 32'hFFFF_FFFF, stkw_pkg::ACT_RESUME, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_KEY_ON, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, stkw_pkg::ACT_ARM, CLOCK_TOP, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(1, 1, stkw_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr_limit) begin
                drain();
                write_limit(dir_rows[i].limit);
            end
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: lim = 32'd1;
                1: lim = 32'hFFFF_FFFF;
                default: begin
                    case ($urandom_range(0, 3))
                        0: lim = $urandom_range(2, 12);
                        1: lim = $urandom_range(13, 60);
                        2: lim = stkw_pkg::MAX_HOLD_RESET;
                        default: lim = $urandom_range(1, 5);
                    endcase
                end
            endcase
            write_limit(lim);
            if (ph == 2) hold_off_req = 1'b1;
            no_idle = (ph == 4);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                it = random_command();
                send_item(it, 1'b0, none_want);
            end
        end
        no_idle = 1'b0;
        drain();
        repeat (10) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("scheduled_transmit_key_watchdog_tb: PASS");
        end else begin
            $display("scheduled_transmit_key_watchdog_tb: FAIL");
        end
        $finish;
    end

endmodule
